@@ rtl/dpsl_pkg.sv @@
// shared constants and types for the delay polynomial segment linearizer
package dpsl_pkg;

	localparam int NUM_COEFF = 6;
	localparam int NUM_REG = 8;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_WSTART = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_WSTOP = 3'd7;
	localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_OUT
	} state_t;

	// saturating conversion from sign/magnitude to two's complement
	function automatic logic [63:0] from_signmag(input logic neg, input logic [64:0] mag);
		logic [63:0] r;
		if (neg) begin
			r = (mag > {1'b0, SMIN}) ? SMIN : (64'd0 - mag[63:0]);
		end else begin
			r = (mag > {1'b0, SMAX}) ? SMAX : mag[63:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/dpsl_mul.sv @@
// bit-serial 64x64 unsigned multiplier, one multiplier bit per cycle
module dpsl_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [64:0]  sum;

	// shift-add: add the multiplicand into the top half, shift right
	assign sum = {1'b0, acc_q[127:64]} + (b_q[0] ? {1'b0, a_q} : 65'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[63:1]};
			b_q <= {1'b0, b_q[63:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ rtl/dpsl_div.sv @@
// restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit per cycle
module dpsl_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [127:0] quo
);

	logic [127:0] n_q;
	logic [127:0] q_q;
	logic [63:0]  r_q;
	logic [63:0]  d_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [64:0]  rs;
	logic         ge;

	assign rs = {r_q, n_q[127]};
	assign ge = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[126:0], 1'b0};
			q_q <= {q_q[126:0], ge};
			r_q <= ge ? 64'(rs - {1'b0, d_q}) : rs[63:0];
		end
	end

	assign done = done_q;
	assign quo = q_q;

endmodule

@@ rtl/delay_poly_segment_linearizer.sv @@
// top level: horner evaluation sequencer, segment slope and flags
// Each boundary request is evaluated by Horner's rule on one shared bit-serial
// multiplier. Every step launches a multiply and adds the next coefficient, and six
// coefficients need five steps. A boundary that closes a segment then runs the
// bit-serial divider and the output state; a boundary that opens a sequence emits
// nothing. One request is worked on at a time. The result sits in an output register
// until taken; a new request is accepted and evaluated meanwhile, and only its result
// waits for the register.
module delay_poly_segment_linearizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] boundary_time,
	input  logic        first_boundary,
	input  logic        last_boundary,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] slope,
	output logic [63:0] offset,
	output logic        segment_ok,
	output logic        sequence_ok,
	output logic        last_segment
);

	logic [63:0] regs_q [dpsl_pkg::NUM_REG];
	dpsl_pkg::state_t state_q, state_d;

	logic [63:0] t_q;
	logic        first_q, last_q;
	logic        xneg_q;
	logic [63:0] xmag_q;
	logic [63:0] y_q;
	logic [2:0]  k_q;
	logic [63:0] prev_time_q, prev_value_q;
	logic        have_prev_q, all_valid_q;
	logic        out_valid_q;
	logic [63:0] slope_q, offset_q;
	logic        seg_ok_q, seq_ok_q, last_seg_q;
	logic        ok_q, dneg_q, zero_dt_q;

	logic         mul_start, mul_done, div_start, div_done;
	logic [63:0]  ymag;
	logic [127:0] prod, quo;
	logic [127:0] div_num;
	logic [63:0]  div_den;

	logic        yneg, pneg, cneg;
	logic [63:0] c, cm, pm;
	logic [63:0] y_next;
	logic [63:0] ws;
	logic        is_seg;
	logic        xneg_in;
	logic [63:0] xmag_in;
	logic        dtneg, dyneg, ok_c;
	logic [63:0] dtmag, dymag;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	assign ws = regs_q[dpsl_pkg::REG_WSTART];
	assign xneg_in = boundary_time < ws;
	assign xmag_in = xneg_in ? ws - boundary_time : boundary_time - ws;

	assign yneg = y_q[63];
	assign ymag = yneg ? 64'd0 - y_q : y_q;
	assign pneg = yneg != xneg_q;
	assign c = regs_q[k_q];
	assign cneg = c[63];
	assign cm = cneg ? 64'd0 - c : c;
	assign pm = {prod[95:64], prod[63:32]};

	// one saturating signed add of the scaled product and the coefficient
	always_comb begin
		logic [64:0] s;
		s = '0;
		if (prod[127:96] != 32'd0) begin
			y_next = pneg ? dpsl_pkg::SMIN : dpsl_pkg::SMAX;
		end else if (pneg == cneg) begin
			s = {1'b0, pm} + {1'b0, cm};
			y_next = s[64] ? (pneg ? dpsl_pkg::SMIN : dpsl_pkg::SMAX)
				: dpsl_pkg::from_signmag(pneg, s);
		end else if (pm >= cm) begin
			y_next = dpsl_pkg::from_signmag(pneg, {1'b0, pm - cm});
		end else begin
			y_next = dpsl_pkg::from_signmag(cneg, {1'b0, cm - pm});
		end
	end

	assign is_seg = !first_q && have_prev_q;
	assign dtneg = t_q < prev_time_q;
	assign dtmag = dtneg ? prev_time_q - t_q : t_q - prev_time_q;
	assign dyneg = $signed(y_q) < $signed(prev_value_q);
	assign dymag = dyneg ? prev_value_q - y_q : y_q - prev_value_q;
	assign ok_c = !(t_q > regs_q[dpsl_pkg::REG_WSTOP] || prev_time_q < ws || dtneg);
	assign div_num = {32'd0, dymag, 32'd0};
	assign div_den = dtmag;

	dpsl_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(ymag), .b(xmag_q), .done(mul_done), .prod(prod)
	);

	dpsl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .done(div_done), .quo(quo)
	);

	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			dpsl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_ready) begin
					state_d = (dpsl_pkg::NUM_COEFF > 1) ? dpsl_pkg::ST_ADD : dpsl_pkg::ST_DIV;
				end
			end
			dpsl_pkg::ST_ADD: begin
				// k points at next coefficient; launch the multiply that comes before its add
				if (k_q < 3'(dpsl_pkg::NUM_COEFF)) begin
					mul_start = 1'b1;
					state_d = dpsl_pkg::ST_MUL;
				end else begin
					state_d = dpsl_pkg::ST_DIV;
				end
			end
			dpsl_pkg::ST_MUL: begin
				if (mul_done) state_d = dpsl_pkg::ST_ADD;
			end
			dpsl_pkg::ST_DIV: begin
				if (!is_seg) begin
					state_d = dpsl_pkg::ST_IDLE;
				end else if (zero_dt_q) begin
					if (div_done) state_d = dpsl_pkg::ST_OUT;
				end else begin
					if (div_done) state_d = dpsl_pkg::ST_OUT;
				end
			end
			dpsl_pkg::ST_OUT: begin
				if (out_free) state_d = dpsl_pkg::ST_IDLE;
			end
			default: state_d = dpsl_pkg::ST_IDLE;
		endcase
	end

	// division start pulse issued on the cycle we enter ST_DIV
	logic div_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpsl_pkg::ST_IDLE;
			for (int i = 0; i < dpsl_pkg::NUM_REG; i++) begin
				regs_q[i] <= (i == int'(dpsl_pkg::REG_WSTOP)) ? {64{1'b1}} : 64'd0;
			end
			prev_time_q <= '0;
			prev_value_q <= '0;
			have_prev_q <= 1'b0;
			all_valid_q <= 1'b1;
			out_valid_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			div_go_q <= 1'b0;
			if (cfg_we) regs_q[cfg_index] <= cfg_data;
			if (out_valid_q && out_ready && state_q != dpsl_pkg::ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != dpsl_pkg::ST_DIV && state_d == dpsl_pkg::ST_DIV) begin
				div_go_q <= 1'b1;
			end
			if (state_q == dpsl_pkg::ST_DIV && !is_seg) begin
				prev_time_q <= t_q;
				prev_value_q <= y_q;
				have_prev_q <= 1'b1;
				all_valid_q <= 1'b1;
			end
			if (state_q == dpsl_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				all_valid_q <= all_valid_q && ok_q;
				prev_time_q <= t_q;
				prev_value_q <= y_q;
				if (last_q) have_prev_q <= 1'b0;
			end
		end
	end

	assign div_start = div_go_q && is_seg;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			t_q <= boundary_time;
			first_q <= first_boundary;
			last_q <= last_boundary;
			xneg_q <= xneg_in;
			xmag_q <= xmag_in;
			y_q <= regs_q[0];
			k_q <= 3'd1;
		end
		if (state_q == dpsl_pkg::ST_MUL && mul_done) begin
			y_q <= y_next;
			k_q <= k_q + 3'd1;
		end
		if (div_go_q) begin
			ok_q <= ok_c;
			dneg_q <= dyneg != dtneg;
			zero_dt_q <= t_q == prev_time_q;
		end
		if (state_q == dpsl_pkg::ST_OUT && out_free) begin
			if (zero_dt_q) slope_q <= '0;
			else if (quo[127:64] != 64'd0) slope_q <= dneg_q ? dpsl_pkg::SMIN : dpsl_pkg::SMAX;
			else slope_q <= dpsl_pkg::from_signmag(dneg_q, {1'b0, quo[63:0]});
			offset_q <= prev_value_q;
			seg_ok_q <= ok_q;
			seq_ok_q <= all_valid_q && ok_q;
			last_seg_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign slope = slope_q;
	assign offset = offset_q;
	assign segment_ok = seg_ok_q;
	assign sequence_ok = seq_ok_q;
	assign last_segment = last_seg_q;

endmodule

@@ tb/tb.sv @@
// testbench for the delay polynomial segment linearizer: scoreboard class, drivers, checks
module tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] boundary_time;
	logic        first_boundary;
	logic        last_boundary;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] slope;
	logic [63:0] offset;
	logic        segment_ok;
	logic        sequence_ok;
	logic        last_segment;

	typedef struct packed {
		logic [63:0] slope;
		logic [63:0] offset;
		logic        seg_ok;
		logic        seq_ok;
		logic        last;
	} segment_t;

	int err_count = 0;
	longint unsigned cycle_count = 0;
	bit quiet = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		err_count++;
	endtask

	class segment_scoreboard;
		logic [63:0] coeff_reg [dpsl_pkg::NUM_REG];
		logic [63:0] prev_t;
		logic [63:0] prev_y;
		bit          open_seq;
		bit          seq_valid;
		segment_t    pending[$];

		function new();
			foreach (coeff_reg[i]) coeff_reg[i] = 64'd0;
			coeff_reg[dpsl_pkg::REG_WSTOP] = '1;
			prev_t = '0;
			prev_y = '0;
			open_seq = 0;
			seq_valid = 1;
		endfunction

		function void write_reg(input int idx, input logic [63:0] v);
			coeff_reg[idx] = v;
		endfunction

		function logic [63:0] clamp(input logic signed [129:0] v);
			if (v > $signed({66'd0, dpsl_pkg::SMAX})) return dpsl_pkg::SMAX;
			if (v < -$signed({66'd0, dpsl_pkg::SMIN})) return dpsl_pkg::SMIN;
			return v[63:0];
		endfunction

		// horner with exact products, truncation toward zero, per-step saturation
		function logic [63:0] horner(input logic [63:0] t);
			logic signed [129:0] x, y, p;
			logic [129:0] pm;
			int k;
			x = $signed({66'd0, t}) - $signed({66'd0, coeff_reg[dpsl_pkg::REG_WSTART]});
			y = $signed(coeff_reg[0]);
			for (k = 1; k < dpsl_pkg::NUM_COEFF; k++) begin
				p = y * x;
				pm = p < 0 ? -p : p;
				pm = pm >> 32;
				p = p < 0 ? -$signed(pm) : $signed(pm);
				if (pm >= (130'd1 << 64)) y = $signed(clamp(p));
				else y = $signed(clamp(p + $signed(coeff_reg[k])));
				y = $signed(y[63:0]);
			end
			return y[63:0];
		endfunction

		function logic [63:0] rate(input logic [63:0] y1, y2, t1, t2);
			logic signed [129:0] dy, dt, q;
			logic [129:0] dym, dtm, qm;
			if (t1 == t2) return 64'd0;
			dy = $signed(y2) - $signed(y1);
			dt = $signed({66'd0, t2}) - $signed({66'd0, t1});
			dym = dy < 0 ? -dy : dy;
			dtm = dt < 0 ? -dt : dt;
			qm = (dym << 32) / dtm;
			q = ((dy < 0) != (dt < 0)) ? -$signed(qm) : $signed(qm);
			return clamp(q);
		endfunction

		function void note_request(input logic [63:0] t, input bit first, input bit last);
			logic [63:0] y;
			segment_t s;
			bit ok;
			y = horner(t);
			if (first || !open_seq) begin
				prev_t = t;
				prev_y = y;
				open_seq = 1;
				seq_valid = 1;
				return;
			end
			ok = !(t > coeff_reg[dpsl_pkg::REG_WSTOP] || prev_t < coeff_reg[dpsl_pkg::REG_WSTART]
				|| t < prev_t);
			seq_valid = seq_valid && ok;
			s.slope = rate(prev_y, y, prev_t, t);
			s.offset = prev_y;
			s.seg_ok = ok;
			s.seq_ok = seq_valid;
			s.last = last;
			pending.push_back(s);
			prev_t = t;
			prev_y = y;
			if (last) open_seq = 0;
		endfunction

		task check_segment(input segment_t got);
			segment_t e;
			if (pending.size() == 0) begin
				report("segment with none expected");
				return;
			end
			e = pending.pop_front();
			if (got.slope !== e.slope)
				report($sformatf("slope %h exp %h", got.slope, e.slope));
			if (got.offset !== e.offset)
				report($sformatf("offset %h exp %h", got.offset, e.offset));
			if (got.seg_ok !== e.seg_ok) report("segment_ok");
			if (got.seq_ok !== e.seq_ok) report("sequence_ok");
			if (got.last !== e.last) report("last_segment");
		endtask
	endclass

	segment_scoreboard sb;

	delay_poly_segment_linearizer DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd3_000_000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: random stall bursts, sample at the edge
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_segment({slope, offset, segment_ok, sequence_ok, last_segment});
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(1, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input int idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays up between back-to-back requests; gaps and drain lower it
	task automatic send_boundary(input logic [63:0] t, input bit first, input bit last);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		boundary_time <= t;
		first_boundary <= first;
		last_boundary <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_request(t, first, last);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_coeff(input int mode);
		case (mode)
			0: return 64'd0;
			1: return dpsl_pkg::SMAX;
			2: return dpsl_pkg::SMIN;
			3: return 64'($signed($urandom_range(0, 2000)) - 1000);
			default: return rand64();
		endcase
	endfunction

	task automatic random_sequence(input int n, input logic [63:0] base, input int span_bits);
		logic [63:0] t;
		int i;
		t = base;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) t = rand64();
			else if ($urandom_range(0, 15) == 0) t = t - ({$urandom, $urandom} >> (64 - span_bits));
			else if ($urandom_range(0, 20) != 0) t = t + ({$urandom, $urandom} >> (64 - span_bits));
			send_boundary(t, i == 0 && $urandom_range(0, 7) != 0,
				i == n - 1 || $urandom_range(0, 30) == 0);
		end
	endtask

	initial begin
		int ph, k, sent;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		boundary_time = '0;
		first_boundary = 1'b0;
		last_boundary = 1'b0;
		out_ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config, no open sequence, first+last, equal/descending
		send_boundary(64'd100, 1'b0, 1'b0);
		send_boundary(64'd100, 1'b0, 1'b0);
		send_boundary(64'd50, 1'b0, 1'b1);
		send_boundary(64'd7, 1'b1, 1'b1);
		send_boundary('1, 1'b0, 1'b1);
		drain();
		write_reg(0, 0); write_reg(1, 0); write_reg(2, 0);
		write_reg(3, 64'd5); write_reg(4, -64'sd3 <<< 32); write_reg(5, dpsl_pkg::SMAX);
		write_reg(int'(dpsl_pkg::REG_WSTART), 64'h0000_0010_0000_0000);
		write_reg(int'(dpsl_pkg::REG_WSTOP), 64'h0000_0100_0000_0000);
		send_boundary(64'd0, 1'b1, 1'b0);
		send_boundary(64'h0000_0010_0000_0000, 1'b0, 1'b0);
		send_boundary(64'h0000_0020_0000_0000, 1'b0, 1'b0);
		send_boundary(64'h0000_0020_0000_0000, 1'b0, 1'b0);
		send_boundary(64'h0000_0200_0000_0000, 1'b0, 1'b0);
		send_boundary('1, 1'b0, 1'b1);
		drain();
		write_reg(0, dpsl_pkg::SMAX); write_reg(1, dpsl_pkg::SMIN); write_reg(2, dpsl_pkg::SMAX);
		write_reg(3, dpsl_pkg::SMIN); write_reg(4, dpsl_pkg::SMAX); write_reg(5, dpsl_pkg::SMIN);
		write_reg(int'(dpsl_pkg::REG_WSTART), '1); write_reg(int'(dpsl_pkg::REG_WSTOP), 0);
		send_boundary(64'd0, 1'b1, 1'b0);
		send_boundary('1, 1'b0, 1'b0);
		send_boundary(64'd1, 1'b0, 1'b1);
		drain();

		sent = 0;
		for (ph = 0; ph < 24; ph++) begin
			for (k = 0; k < 6; k++) write_reg(k, rand_coeff($urandom_range(0, 5)));
			case (ph % 4)
				0: begin
					write_reg(int'(dpsl_pkg::REG_WSTART), 0);
					write_reg(int'(dpsl_pkg::REG_WSTOP), '1);
				end
				1: begin
					write_reg(int'(dpsl_pkg::REG_WSTART), rand64());
					write_reg(int'(dpsl_pkg::REG_WSTOP), rand64());
				end
				default: begin
					write_reg(int'(dpsl_pkg::REG_WSTART), {32'd0, $urandom} << $urandom_range(0, 32));
					write_reg(int'(dpsl_pkg::REG_WSTOP), rand64() | 64'h8000_0000_0000_0000);
				end
			endcase
			if (ph == 20) quiet = 1;
			while (sent < (ph + 1) * 76) begin
				k = $urandom_range(2, 12);
				random_sequence(k,
					sb.coeff_reg[dpsl_pkg::REG_WSTART] + ($urandom >> $urandom_range(0, 31)),
					$urandom_range(1, 64));
				sent += k;
			end
			// coefficient change inside an open sequence
			if (ph % 5 == 0) begin
				send_boundary(sb.coeff_reg[dpsl_pkg::REG_WSTART], 1'b1, 1'b0);
				drain();
				write_reg(5, rand64());
				send_boundary(sb.coeff_reg[dpsl_pkg::REG_WSTART] + 64'd12345, 1'b0, 1'b1);
				sent += 2;
			end
			drain();
		end

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ delay_poly_segment_linearizer.f @@
rtl/dpsl_pkg.sv
rtl/dpsl_mul.sv
rtl/dpsl_div.sv
rtl/delay_poly_segment_linearizer.sv
tb/tb.sv
